### hw/rtl/ltps_pkg.sv
// ----------------------------------------------------------------------------
// Line tracking steering package
// Shared types, register indexes, reset values and the sensor decode table.
// ----------------------------------------------------------------------------
package ltps_pkg;

    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned SPEED_W = 11;
    localparam int unsigned SENS_W  = 4;
    localparam int unsigned ERR_W   = 4;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 16;

    localparam logic [CIDX_W-1:0] CFG_KP     = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_KI     = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_KD     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TARGET = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_BASE   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_MAX    = 3'd5;

    localparam logic signed [GAIN_W-1:0] KP_RST     = -16'sd256;
    localparam logic signed [GAIN_W-1:0] KI_RST     = 16'sd0;
    localparam logic signed [GAIN_W-1:0] KD_RST     = 16'sd205;
    localparam logic signed [POS_W-1:0]  TARGET_RST = 3'sd0;
    localparam logic [SPEED_W-1:0]       BASE_RST   = 11'd768;
    localparam logic [SPEED_W-1:0]       MAX_RST    = 11'd1280;

    localparam logic signed [POS_W-1:0] POS_ILLEGAL = 3'b100;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [POS_W-1:0]  target;
        logic [SPEED_W-1:0]       base;
        logic [SPEED_W-1:0]       max;
    } t_cfg;

    typedef struct packed {
        logic                     changed;
        logic [SPEED_W-1:0]       left;
        logic [SPEED_W-1:0]       right;
        logic signed [POS_W-1:0]  pos;
    } t_result;

    typedef struct packed {
        logic                     known;
        logic signed [POS_W-1:0]  pos;
    } t_decode;

    function automatic t_decode decode_sensors(input logic [SENS_W-1:0] bits);
        t_decode d;
        d.known = 1'b1;
        case (bits)
            4'b0000: d.pos = 3'sd0;
            4'b0001: d.pos = -3'sd2;
            4'b0010: d.pos = -3'sd1;
            4'b0011: d.pos = -3'sd3;
            4'b0100: d.pos = 3'sd1;
            4'b1000: d.pos = 3'sd2;
            4'b1100: d.pos = 3'sd3;
            default: begin
                d.known = 1'b0;
                d.pos   = 3'sd0;
            end
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/ltps_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the gains, target position and speed limits written over the
// configuration channel. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module ltps_cfg_regs
    import ltps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CDATA_W-1:0] i_cfg_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KP:     n_cfg.kp     = i_cfg_data;
                CFG_KI:     n_cfg.ki     = i_cfg_data;
                CFG_KD:     n_cfg.kd     = i_cfg_data;
                CFG_TARGET: n_cfg.target = i_cfg_data[POS_W-1:0];
                CFG_BASE:   n_cfg.base   = i_cfg_data[SPEED_W-1:0];
                CFG_MAX:    n_cfg.max    = i_cfg_data[SPEED_W-1:0];
                default:    n_cfg        = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp     <= KP_RST;
            r_cfg.ki     <= KI_RST;
            r_cfg.kd     <= KD_RST;
            r_cfg.target <= TARGET_RST;
            r_cfg.base   <= BASE_RST;
            r_cfg.max    <= MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/ltps_pid_core.sv
// ----------------------------------------------------------------------------
// Steering PID datapath
// Decodes the sensor pattern, runs the positional PID and clamps both wheel
// setpoints. Holds the position, previous error and integral state.
// ----------------------------------------------------------------------------
module ltps_pid_core
    import ltps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_step,
    input  logic [SENS_W-1:0] i_sensor_bits,
    output t_result           o_res
);

    logic signed [POS_W-1:0]   r_held_pos;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [SUM_W-1:0]   r_err_sum;

    t_decode                   w_dec;
    logic signed [POS_W-1:0]   w_pos;
    logic signed [POS_W-1:0]   w_target;
    logic signed [GAIN_W-1:0]  w_kp;
    logic signed [GAIN_W-1:0]  w_ki;
    logic signed [GAIN_W-1:0]  w_kd;
    logic signed [ERR_W-1:0]   w_err;
    logic signed [ERR_W:0]     w_de;
    logic signed [SUM_W:0]     w_sum_wide;
    logic signed [SUM_W-1:0]   n_err_sum;
    logic signed [19:0]        w_p_term;
    logic signed [31:0]        w_i_term;
    logic signed [20:0]        w_d_term;
    logic signed [32:0]        w_drive;
    logic signed [33:0]        w_base;
    logic signed [33:0]        w_top;
    logic signed [33:0]        w_left;
    logic signed [33:0]        w_right;

    always_comb begin
        w_dec    = decode_sensors(i_sensor_bits);
        w_pos    = w_dec.known ? w_dec.pos : r_held_pos;
        w_target = i_cfg.target;
        w_kp     = i_cfg.kp;
        w_ki     = i_cfg.ki;
        w_kd     = i_cfg.kd;

        w_err      = ERR_W'(w_target) - ERR_W'(w_pos);
        w_de       = (ERR_W+1)'(w_err) - (ERR_W+1)'(r_prev_err);
        w_sum_wide = (SUM_W+1)'(r_err_sum) + (SUM_W+1)'(w_err);
        if (w_sum_wide > 17'sd32767) begin
            n_err_sum = 16'sd32767;
        end else if (w_sum_wide < -17'sd32768) begin
            n_err_sum = -16'sd32768;
        end else begin
            n_err_sum = w_sum_wide[SUM_W-1:0];
        end

        w_p_term = 20'(w_kp) * 20'(w_err);
        w_i_term = 32'(w_ki) * 32'(n_err_sum);
        w_d_term = 21'(w_kd) * 21'(w_de);
        w_drive  = 33'(w_p_term) + 33'(w_i_term) + 33'(w_d_term);

        w_base  = 34'(signed'({1'b0, i_cfg.base}));
        w_top   = 34'(signed'({1'b0, i_cfg.max}));
        w_left  = w_base + 34'(w_drive);
        w_right = w_base - 34'(w_drive);

        o_res.changed = (w_pos != r_held_pos);
        o_res.pos     = w_pos;
        if (w_left < 34'sd0) begin
            o_res.left = '0;
        end else if (w_left > w_top) begin
            o_res.left = i_cfg.max;
        end else begin
            o_res.left = w_left[SPEED_W-1:0];
        end
        if (w_right < 34'sd0) begin
            o_res.right = '0;
        end else if (w_right > w_top) begin
            o_res.right = i_cfg.max;
        end else begin
            o_res.right = w_right[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pos <= '0;
            r_prev_err <= '0;
            r_err_sum  <= '0;
        end else if (i_step) begin
            r_held_pos <= w_pos;
            r_prev_err <= w_err;
            r_err_sum  <= n_err_sum;
        end
    end

endmodule

### hw/rtl/line_track_pid_steering_core.sv
// ----------------------------------------------------------------------------
// Line tracking PID steering core
// A result is registered only for a sensor beat that moves the line position.
// Throughput: one sensor beat per cycle; a beat that moves the position stalls
// on a full result register; input ready follows output ready combinationally.
// Reset clears the pipeline and PID state and restores the register defaults.
// ----------------------------------------------------------------------------
module line_track_pid_steering_core
    import ltps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [SENS_W-1:0]  i_sensor_bits,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [SPEED_W-1:0] o_left_speed,
    output logic [SPEED_W-1:0] o_right_speed,
    output logic [POS_W-1:0]   o_line_position,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CDATA_W-1:0] i_cfg_data
);

    t_cfg              w_cfg;
    t_result           w_res;
    logic              w_out_free;
    logic              w_step;

    logic              r_in_valid;
    logic [SENS_W-1:0] r_in_bits;
    logic              r_out_valid;
    t_result           r_out;

    ltps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ltps_pid_core u_pid (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_step        (w_step),
        .i_sensor_bits (r_in_bits),
        .o_res         (w_res)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_step     = r_in_valid && (!w_res.changed || w_out_free);
    assign o_in_ready = !r_in_valid || w_step;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step && w_res.changed) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_bits <= i_sensor_bits;
        end
        if (w_step && w_res.changed) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_speed    = r_out.left;
    assign o_right_speed   = r_out.right;
    assign o_line_position = r_out.pos;

    a_no_illegal_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_line_position != POS_ILLEGAL))
        else $error("result carries an impossible line position");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("empty input stage refuses a beat");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> (r_in_valid && $stable(r_in_bits)))
        else $error("stalled sensor beat was lost or altered");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_res.changed) |=> o_out_valid)
        else $error("position change did not produce a result");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line tracking PID steering core testbench
// Sensor beats are sent through a valid/ready driver with random gaps, and
// wheel setpoint beats are taken with random back-pressure. A predictor in
// the testbench decodes each accepted sensor beat, runs the PID with its own
// copy of the gains and state, and queues the expected setpoint whenever the
// line position moves. Each received setpoint is checked field by field
// against the oldest entry. Gains, target and speeds are rewritten between
// phases while the core is idle.
// ----------------------------------------------------------------------------
module tb;
    import ltps_pkg::*;

    localparam logic [CIDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int SUM_HI        = 2 ** (SUM_W - 1) - 1;
    localparam int SUM_LO        = -(2 ** (SUM_W - 1));
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CHUNK_BEATS   = 100;
    localparam int CHUNKS        = 13;

    typedef struct packed {
        logic [SPEED_W-1:0]      left;
        logic [SPEED_W-1:0]      right;
        logic signed [POS_W-1:0] pos;
    } t_setpoint;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic               o_in_ready;
    logic [SENS_W-1:0]  i_sensor_bits   = '0;
    logic               o_out_valid;
    logic               i_out_ready     = 1'b0;
    logic [SPEED_W-1:0] o_left_speed;
    logic [SPEED_W-1:0] o_right_speed;
    logic [POS_W-1:0]   o_line_position;
    logic               i_cfg_valid     = 1'b0;
    logic               o_cfg_ready;
    logic [CIDX_W-1:0]  i_cfg_index     = '0;
    logic [CDATA_W-1:0] i_cfg_data      = '0;

    logic [SENS_W-1:0] sensor_q[$];
    t_setpoint         setpoint_q[$];
    int                send_idle_pct  = 11;
    int                recv_idle_pct  = 78;
    bit                recv_hold      = 1'b0;
    bit                in_fire        = 1'b0;
    int                fault_count    = 0;
    logic [SENS_W-1:0] last_known_pat = '0;

    t_cfg                    steer_cfg;
    logic signed [POS_W-1:0] held_pos;
    logic signed [ERR_W-1:0] last_err;
    logic signed [SUM_W-1:0] err_sum;

    line_track_pid_steering_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_sensor_bits   (i_sensor_bits),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_left_speed    (o_left_speed),
        .o_right_speed   (o_right_speed),
        .o_line_position (o_line_position),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit sensor_position(input logic [SENS_W-1:0] bits,
                                           output logic signed [POS_W-1:0] pos);
        sensor_position = 1'b1;
        pos = 3'sd0;
        case (bits)
            4'b0000: pos = 3'sd0;
            4'b0010: pos = -3'sd1;
            4'b0001: pos = -3'sd2;
            4'b0011: pos = -3'sd3;
            4'b0100: pos = 3'sd1;
            4'b1000: pos = 3'sd2;
            4'b1100: pos = 3'sd3;
            default: sensor_position = 1'b0;
        endcase
    endfunction

    function automatic longint wheel_clamp(input longint v);
        if (v > longint'(steer_cfg.max)) v = longint'(steer_cfg.max);
        if (v < 0) v = 0;
        return v;
    endfunction

    // Runs one PID tick and reports whether the line position moved.
    function automatic bit steer_predict(input logic [SENS_W-1:0] bits,
                                         output t_setpoint sp);
        logic signed [POS_W-1:0] pos;
        int     err;
        int     slope;
        int     acc;
        longint drive;
        bit     moved;
        if (!sensor_position(bits, pos)) pos = held_pos;
        err   = int'($signed(steer_cfg.target)) - int'(pos);
        slope = err - int'(last_err);
        acc   = int'(err_sum) + err;
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        drive = longint'($signed(steer_cfg.kp)) * err
              + longint'($signed(steer_cfg.ki)) * acc
              + longint'($signed(steer_cfg.kd)) * slope;
        sp.left  = SPEED_W'(wheel_clamp(longint'(steer_cfg.base) + drive));
        sp.right = SPEED_W'(wheel_clamp(longint'(steer_cfg.base) - drive));
        sp.pos   = pos;
        moved    = (pos != held_pos);
        err_sum  = SUM_W'(acc);
        last_err = ERR_W'(err);
        held_pos = pos;
        return moved;
    endfunction

    always @(posedge i_clk) begin
        t_setpoint want;
        t_setpoint sp;
        if (!i_rst_n) begin
            steer_cfg.kp     = KP_RST;
            steer_cfg.ki     = KI_RST;
            steer_cfg.kd     = KD_RST;
            steer_cfg.target = TARGET_RST;
            steer_cfg.base   = BASE_RST;
            steer_cfg.max    = MAX_RST;
            held_pos = '0;
            last_err = '0;
            err_sum  = '0;
            in_fire  = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (setpoint_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: setpoint beat with none expected: left %0d right %0d pos %0d",
                                 $time, o_left_speed, o_right_speed, $signed(o_line_position));
                end else begin
                    want = setpoint_q.pop_front();
                    if (want.left !== o_left_speed || want.right !== o_right_speed ||
                        want.pos !== o_line_position) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: expected left %0d right %0d pos %0d, got left %0d right %0d pos %0d",
                                     $time, want.left, want.right, $signed(want.pos),
                                     o_left_speed, o_right_speed, $signed(o_line_position));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KP:     steer_cfg.kp = i_cfg_data;
                    CFG_KI:     steer_cfg.ki = i_cfg_data;
                    CFG_KD:     steer_cfg.kd = i_cfg_data;
                    CFG_TARGET: steer_cfg.target = i_cfg_data[POS_W-1:0];
                    CFG_BASE:   steer_cfg.base = i_cfg_data[SPEED_W-1:0];
                    CFG_MAX:    steer_cfg.max = i_cfg_data[SPEED_W-1:0];
                    default: ;
                endcase
            end
            in_fire = i_in_valid && o_in_ready;
            if (in_fire && steer_predict(i_sensor_bits, sp)) setpoint_q.push_back(sp);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (sensor_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid    <= 1'b1;
                i_sensor_bits <= sensor_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (sensor_q.size() != 0 || i_in_valid || setpoint_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_nibbles(input logic [79:0] seq, input int count);
        for (int i = count - 1; i >= 0; i--) sensor_q.push_back(seq[i*4 +: 4]);
    endtask

    function automatic logic [CDATA_W-1:0] rand_gain();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return CDATA_W'($urandom_range(65535));
            default: return CDATA_W'(int'($urandom_range(1200)) - 600);
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return SPEED_W'($urandom_range(2047));
        endcase
    endfunction

    // Mostly known patterns, some repeats of the last one, some unknown patterns.
    function automatic logic [SENS_W-1:0] random_sensor();
        logic [SENS_W-1:0]       bits;
        logic signed [POS_W-1:0] pos;
        int                      roll;
        roll = $urandom_range(99);
        if (roll < 30) return last_known_pat;
        do bits = SENS_W'($urandom_range(15));
        while ((roll < 85) != sensor_position(bits, pos));
        if (roll < 85) last_known_pat = bits;
        return bits;
    endfunction

    task automatic randomise_steering();
        write_reg(CFG_KP, rand_gain());
        write_reg(CFG_KI, ($urandom_range(1) != 0) ? rand_gain()
                                                  : CDATA_W'(int'($urandom_range(6)) - 3));
        write_reg(CFG_KD, rand_gain());
        write_reg(CFG_TARGET, CDATA_W'($urandom));
        write_reg(CFG_BASE, {5'($urandom), rand_speed()});
        write_reg(CFG_MAX, {5'($urandom), rand_speed()});
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every sensor pattern under the reset gains, unknown ones holding position.
        push_nibbles(80'h0123_48C5_679A_BDEF_0C33, 20);
        drain();
        write_reg(CFG_TARGET, 16'h0004);
        write_reg(CFG_KP, 16'h7FFF);
        write_reg(CFG_KI, 16'h8000);
        write_reg(CFG_KD, 16'h8000);
        write_reg(CFG_BASE, 16'hFFFF);
        write_reg(CFG_MAX, 16'h07FF);
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h5A5A);
        push_nibbles(80'hC3081, 5);

        for (int c = 0; c < CHUNKS; c++) begin
            drain();
            if (c == 5) begin
                send_idle_pct = 78;
                recv_idle_pct = 11;
            end else if (c == 10) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            randomise_steering();
            for (int i = 0; i < CHUNK_BEATS; i++) sensor_q.push_back(random_sensor());
            if (c == 2) begin
                @(posedge i_clk);
                recv_hold = 1'b1;
                fork
                    begin
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        recv_hold = 1'b0;
                    end
                join_none
            end
        end

        drain();
        if (fault_count == 0 && setpoint_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
